// ===== design/kta_pkg.sv =====
package kta_pkg;

	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam int TABLE_SIZE = 186;
	localparam logic [7:0] LEFT_SHIFT_KEY  = 8'd151;
	localparam logic [7:0] RIGHT_SHIFT_KEY = 8'd152;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] key_code;
	} kta_cmd_t;

	typedef struct packed {
		logic [7:0] read_char;
		logic       char_valid;
		logic       chars_ready;
		logic       dropped_oldest;
	} kta_result_t;

	// ring status for the beat in flight, handed to the result register
	typedef struct packed {
		logic popped;
		logic ready;
		logic dropped;
	} kta_ring_stat_t;

	localparam logic [7:0] PLAIN_MAP [0:TABLE_SIZE-1] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd8,   8'd9,   8'd0,   8'd0,   8'd0,   8'd13,  8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd27,  8'd0,   8'd0,   8'd0,   8'd0,
		8'd32,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd39,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd44,  8'd45,  8'd46,  8'd47,
		8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,
		8'd56,  8'd57,  8'd0,   8'd59,  8'd0,   8'd61,  8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd91,  8'd92,  8'd93,  8'd0,   8'd0,
		8'd96,  8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103,
		8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111,
		8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
		8'd120, 8'd121, 8'd122, 8'd0,   8'd0,   8'd0,   8'd0,   8'd127,
		8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135,
		8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd13,  8'd142, 8'd143,
		8'd144, 8'd145, 8'd0,   8'd0,   8'd148, 8'd149, 8'd0,   8'd0,
		8'd0,   8'd153, 8'd154, 8'd155, 8'd156, 8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd42,  8'd43,  8'd172, 8'd45,  8'd46,  8'd47,
		8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,
		8'd56,  8'd57
	};

	localparam logic [7:0] SHIFT_MAP [0:TABLE_SIZE-1] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd8,   8'd147, 8'd0,   8'd0,   8'd0,   8'd161, 8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd27,  8'd0,   8'd0,   8'd0,   8'd0,
		8'd32,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd34,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd60,  8'd95,  8'd62,  8'd63,
		8'd41,  8'd33,  8'd64,  8'd35,  8'd36,  8'd37,  8'd94,  8'd38,
		8'd42,  8'd40,  8'd0,   8'd58,  8'd0,   8'd43,  8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd123, 8'd124, 8'd125, 8'd0,   8'd0,
		8'd126, 8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,
		8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
		8'd80,  8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,
		8'd88,  8'd89,  8'd90,  8'd0,   8'd0,   8'd0,   8'd0,   8'd127,
		8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135,
		8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd13,  8'd142, 8'd162,
		8'd163, 8'd164, 8'd0,   8'd0,   8'd165, 8'd166, 8'd0,   8'd0,
		8'd0,   8'd186, 8'd187, 8'd188, 8'd189, 8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd42,  8'd43,  8'd172, 8'd45,  8'd46,  8'd47,
		8'd143, 8'd148, 8'd154, 8'd149, 8'd155, 8'd0,   8'd156, 8'd144,
		8'd153, 8'd145
	};

	function automatic logic [7:0] key_char(input logic [7:0] key, input logic shifted);
		logic [7:0] ch;
		if (int'(key) >= TABLE_SIZE)
			ch = 8'd0;
		else if (shifted)
			ch = SHIFT_MAP[key];
		else
			ch = PLAIN_MAP[key];
		return ch;
	endfunction

endpackage

// ===== design/kta_translate.sv =====
module kta_translate import kta_pkg::*; #(
	parameter int KEY_COUNT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld,
	input  kta_cmd_t   cmd,
	output logic [7:0] char_out
);

	// Only the shift keys' hold counts reach any result. A saturating count
	// is nonzero exactly when the key has been pressed since its last release,
	// so one flag per shift key carries all that matters.
	logic l_held_q;
	logic r_held_q;
	logic in_range;
	logic is_l;
	logic is_r;
	logic press;
	logic release_k;
	logic shifted;

	assign in_range  = int'(cmd.key_code) < KEY_COUNT;
	assign is_l      = cmd.key_code == LEFT_SHIFT_KEY;
	assign is_r      = cmd.key_code == RIGHT_SHIFT_KEY;
	assign press     = vld && cmd.opcode == OP_PRESS && in_range;
	assign release_k = vld && cmd.opcode == OP_RELEASE && in_range;

	// the press of a shift key counts itself before translation
	assign shifted  = l_held_q || r_held_q || (press && (is_l || is_r));
	assign char_out = press ? key_char(cmd.key_code, shifted) : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_held_q <= 1'b0;
			r_held_q <= 1'b0;
		end else begin
			if (press && is_l)
				l_held_q <= 1'b1;
			else if (release_k && is_l)
				l_held_q <= 1'b0;
			if (press && is_r)
				r_held_q <= 1'b1;
			else if (release_k && is_r)
				r_held_q <= 1'b0;
		end
	end

endmodule

// ===== design/kta_ring.sv =====
module kta_ring import kta_pkg::*; #(
	parameter int RING_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [7:0]     push_char,
	input  logic           pop_req,
	output kta_ring_stat_t stat,
	output logic [7:0]     rd_data_q
);

	localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);

	logic [7:0]    mem [0:RING_DEPTH-1];
	logic [PW-1:0] wr_slot_q;
	logic [PW-1:0] rd_slot_q;
	logic          ready_q;
	logic [PW-1:0] wr_next;
	logic [PW-1:0] rd_next;
	logic          pop;
	logic          drop;

	assign wr_next = (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + 1'b1;
	assign rd_next = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + 1'b1;
	assign pop     = pop_req && ready_q;
	// writing into the slot just behind the oldest pushes the read side on by one
	assign drop    = push && (wr_next == rd_slot_q);

	always_comb begin
		stat.popped  = pop;
		stat.dropped = drop;
		if (push)
			stat.ready = 1'b1;
		else if (pop)
			stat.ready = rd_next != wr_slot_q;
		else
			stat.ready = ready_q;
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_slot_q] <= push_char;
		rd_data_q <= mem[rd_slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			ready_q   <= 1'b0;
		end else begin
			ready_q <= stat.ready;
			if (push)
				wr_slot_q <= wr_next;
			if (drop || pop)
				rd_slot_q <= rd_next;
		end
	end

endmodule

// ===== design/keycode_to_ascii_key_buffer.sv =====
// An accepted command is registered in vld_s1/cmd_s1, translated and applied
// to the ring; its status is registered in vld_s2/stat_s2 and strobed by done.
// Throughput: one command per cycle; busy is low at all times after reset and
// the result side never stalls.
// Reset: asynchronous, active low; clears shift state, ring pointers and
// the strobe; busy stays high until the first edge after release.
module keycode_to_ascii_key_buffer import kta_pkg::*; #(
	parameter int RING_DEPTH = 32,
	parameter int KEY_COUNT  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  kta_cmd_t    cmd,
	output logic        done,
	output kta_result_t result
);

	logic           busy_q;
	logic           vld_s1;
	kta_cmd_t       cmd_s1;
	logic           vld_s2;
	kta_ring_stat_t stat_s2;
	kta_ring_stat_t stat;
	logic [7:0]     char_s1;
	logic [7:0]     rd_data;
	logic           push;
	logic           pop_req;

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			vld_s1 <= start && !busy_q;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q)
			cmd_s1 <= cmd;
		stat_s2 <= stat;
	end

	kta_translate #(
		.KEY_COUNT(KEY_COUNT)
	) u_translate (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_s1),
		.cmd     (cmd_s1),
		.char_out(char_s1)
	);

	assign push    = char_s1 != 8'd0;
	assign pop_req = vld_s1 && cmd_s1.opcode == OP_READ;

	kta_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_char(char_s1),
		.pop_req  (pop_req),
		.stat     (stat),
		.rd_data_q(rd_data)
	);

	assign done                  = vld_s2;
	assign result.read_char      = stat_s2.popped ? rd_data : 8'd0;
	assign result.char_valid     = stat_s2.popped;
	assign result.chars_ready    = stat_s2.ready;
	assign result.dropped_oldest = stat_s2.dropped;

endmodule

// ===== design/kta_checker.sv =====
module kta_checker import kta_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input kta_cmd_t    cmd,
	input logic        done,
	input kta_result_t result
);

	// every accepted beat comes back with done, and nothing else does
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted beat produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##2 !done)
		else $error("result without an accepted beat");

	a_pop_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.char_valid |-> $past(cmd.opcode, 2) == OP_READ)
		else $error("character popped by a non-read beat");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.dropped_oldest |->
			result.chars_ready && !result.char_valid && $past(cmd.opcode, 2) == OP_PRESS)
		else $error("overwrite flagged on a beat that cannot overwrite");

	a_idle_char: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.char_valid |-> result.read_char == 8'd0)
		else $error("character shown without a pop");

endmodule

bind keycode_to_ascii_key_buffer kta_checker u_kta_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done),
	.result(result)
);
